// ===== hw/rtl/eulr_pkg.sv =====
// shared types, constants and the cordic arctangent table for the euler rate block
// no dependencies; imported by every module of the block
`default_nettype none

package eulr_pkg;

  // cordic configuration
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CS_USED      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // singularity threshold register reset value
  localparam logic [14:0] MIN_COS_RESET = 15'd328;

  // fixed point constants on the cordic datapath
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sh0_26DD_3B6A;
  localparam logic signed [33:0] ONE_Q30      = 34'sh0_4000_0000;
  localparam logic signed [33:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF_TURN    = 34'sh0_8000_0000;

  // input word
  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] world_rate_x;
    logic signed [15:0] world_rate_y;
    logic signed [15:0] world_rate_z;
  } eulr_in_t;

  // result word
  typedef struct packed {
    logic signed [19:0] roll_rate;
    logic signed [19:0] pitch_rate;
    logic signed [19:0] yaw_rate;
    logic               singular;
  } eulr_out_t;

  // classified word handed from front to back, trig values in q1.30
  typedef struct packed {
    logic signed [31:0] sf;
    logic signed [31:0] cf;
    logic signed [31:0] st;
    logic signed [31:0] ct;
    logic signed [31:0] sp;
    logic signed [31:0] cp;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic [30:0]        ud;
    logic               sing;
  } eulr_wd_t;

  // queue status
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } eulr_qstat_t;

  // arctangent of 2^-i in 32-bit binary angle units
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:    v = 34'sh0_2000_0000;
      5'd1:    v = 34'sh0_12E4_051E;
      5'd2:    v = 34'sh0_09FB_385B;
      5'd3:    v = 34'sh0_0511_11D4;
      5'd4:    v = 34'sh0_028B_0D43;
      5'd5:    v = 34'sh0_0145_D7E1;
      5'd6:    v = 34'sh0_00A2_F61E;
      5'd7:    v = 34'sh0_0051_7C55;
      5'd8:    v = 34'sh0_0028_BE53;
      5'd9:    v = 34'sh0_0014_5F2F;
      5'd10:   v = 34'sh0_000A_2F98;
      5'd11:   v = 34'sh0_0005_17CC;
      5'd12:   v = 34'sh0_0002_8BE6;
      5'd13:   v = 34'sh0_0001_45F3;
      5'd14:   v = 34'sh0_0000_A2FA;
      5'd15:   v = 34'sh0_0000_517D;
      5'd16:   v = 34'sh0_0000_28BE;
      5'd17:   v = 34'sh0_0000_145F;
      5'd18:   v = 34'sh0_0000_0A30;
      5'd19:   v = 34'sh0_0000_0518;
      5'd20:   v = 34'sh0_0000_028C;
      5'd21:   v = 34'sh0_0000_0146;
      5'd22:   v = 34'sh0_0000_00A3;
      5'd23:   v = 34'sh0_0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eulr_front.sv =====
// front end: accepts words, runs three pipelined cordics and flags singular pitch
// depends on eulr_pkg
`default_nettype none

module eulr_front import eulr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  eulr_in_t    item,
  input  logic [14:0] min_cos,
  input  logic        q_full,
  output logic        push,
  output eulr_wd_t    wd
);

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cor_t;

  typedef struct packed {
    cor_t               roll;
    cor_t               pitch;
    cor_t               yaw;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
  } fst_t;

  // quadrant fold and cordic start vector
  function automatic cor_t cor_load(input logic signed [15:0] a);
    cor_t               c;
    logic signed [33:0] z0;
    z0     = {{2{a[15]}}, a, 16'h0000};
    c.x    = CORDIC_GAIN;
    c.y    = '0;
    c.z    = z0;
    c.flip = 1'b0;
    if (z0 > QUARTER_TURN) begin
      c.z    = z0 - HALF_TURN;
      c.flip = 1'b1;
    end else if (z0 < -QUARTER_TURN) begin
      c.z    = z0 + HALF_TURN;
      c.flip = 1'b1;
    end
    return c;
  endfunction

  // one rotation step
  function automatic cor_t cor_iter(input cor_t c, input logic [4:0] i);
    cor_t               n;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    n  = c;
    if (!c.z[33]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - atan_turn(i);
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + atan_turn(i);
    end
    return n;
  endfunction

  // clamp to +-1.0 and undo the fold
  function automatic logic signed [31:0] cor_out(input logic signed [33:0] v,
                                                 input logic flip);
    logic signed [33:0] t;
    t = v;
    if (v > ONE_Q30) t = ONE_Q30;
    else if (v < -ONE_Q30) t = -ONE_Q30;
    if (flip) t = -t;
    return t[31:0];
  endfunction

  fst_t             fs [CS_USED+1];
  logic [CS_USED:0] fv;
  logic             adv;

  // whole front stalls only when its last stage cannot enter the queue
  assign adv        = !(fv[CS_USED] && q_full);
  assign item_ready = adv;
  assign push       = fv[CS_USED] && !q_full;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[CS_USED-1:0], item_valid};
    end
  end

  // cordic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      fs[0].roll  <= cor_load(item.roll_angle);
      fs[0].pitch <= cor_load(item.pitch_angle);
      fs[0].yaw   <= cor_load(item.yaw_angle);
      fs[0].wx    <= item.world_rate_x;
      fs[0].wy    <= item.world_rate_y;
      fs[0].wz    <= item.world_rate_z;
      for (int k = 0; k < CS_USED; k++) begin
        fs[k+1].roll  <= cor_iter(fs[k].roll, 5'(k));
        fs[k+1].pitch <= cor_iter(fs[k].pitch, 5'(k));
        fs[k+1].yaw   <= cor_iter(fs[k].yaw, 5'(k));
        fs[k+1].wx    <= fs[k].wx;
        fs[k+1].wy    <= fs[k].wy;
        fs[k+1].wz    <= fs[k].wz;
      end
    end
  end

  // classify pitch and build the queue word
  logic [14:0]        mc;
  logic [29:0]        thr;
  logic [30:0]        act;
  logic signed [31:0] ct;

  always_comb begin
    ct      = cor_out(fs[CS_USED].pitch.x, fs[CS_USED].pitch.flip);
    mc      = (min_cos == 15'd0) ? 15'd1 : min_cos;
    thr     = {mc, 15'h0000};
    act     = ct[31] ? 31'(-ct) : 31'(ct);
    wd.sf   = cor_out(fs[CS_USED].roll.y, fs[CS_USED].roll.flip);
    wd.cf   = cor_out(fs[CS_USED].roll.x, fs[CS_USED].roll.flip);
    wd.st   = cor_out(fs[CS_USED].pitch.y, fs[CS_USED].pitch.flip);
    wd.ct   = ct;
    wd.sp   = cor_out(fs[CS_USED].yaw.y, fs[CS_USED].yaw.flip);
    wd.cp   = cor_out(fs[CS_USED].yaw.x, fs[CS_USED].yaw.flip);
    wd.wx   = fs[CS_USED].wx;
    wd.wy   = fs[CS_USED].wy;
    wd.wz   = fs[CS_USED].wz;
    wd.sing = act < {1'b0, thr};
    wd.ud   = wd.sing ? {1'b0, thr} : act;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/eulr_fifo.sv =====
// short queue of classified words between front and back
// depends on eulr_pkg
`default_nettype none

module eulr_fifo import eulr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  eulr_wd_t    wr_data,
  input  logic        pop,
  output eulr_wd_t    rd_data,
  output eulr_qstat_t stat
);

  eulr_wd_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  assign rd_data    = mem[rp];
  assign stat.count = cnt;
  assign stat.empty = (cnt == '0);
  assign stat.full  = (cnt == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

// ===== hw/rtl/eulr_back.sv =====
// back end: body rotation, euler kinematics, pipelined division and output register
// depends on eulr_pkg
`default_nettype none

module eulr_back import eulr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  eulr_wd_t  q_data,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_ready,
  output eulr_out_t result
);

  localparam int NDIV = 31;
  localparam int NPRE = 8;
  localparam int NBV  = NPRE + NDIV;

  typedef struct packed {
    logic signed [31:0] sf, cf, st, ct, sp, cp;
    logic signed [15:0] wx, wy, wz;
    logic               sing;
    logic [30:0]        ud;
    logic               dneg;
    logic signed [31:0] cp_ct, sp_ct, cp_sf, cf_sp, cf_cp, sf_sp, ct_sf, cf_ct;
    logic signed [32:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [48:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
    logic signed [31:0] p, q, r;
    logic signed [31:0] qs, rc, qc, rs;
    logic signed [30:0] u;
    logic signed [31:0] pitch20;
    logic signed [62:0] ust;
    logic [59:0]        ry, rr;
    logic [30:0]        qy, qr;
    logic               ovy, ovr, negy, negr;
  } bk_t;

  // q1.30 product, rounded half up
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] pr;
    logic signed [63:0] sh;
    pr = a * b + 64'sd536870912;
    sh = pr >>> 30;
    return sh[31:0];
  endfunction

  // round to q.10 and saturate to 20 bits
  function automatic logic signed [19:0] to_out(input logic signed [32:0] v);
    logic signed [32:0] t;
    logic signed [19:0] o;
    t = (v + 33'sd512) >>> 10;
    if (t > 33'sd524287) o = 20'sh7FFFF;
    else if (t < -33'sd524288) o = 20'sh80000;
    else o = t[19:0];
    return o;
  endfunction

  // first trig products
  function automatic bk_t st1(input eulr_wd_t w);
    bk_t n;
    n       = '0;
    n.sf    = w.sf;
    n.cf    = w.cf;
    n.st    = w.st;
    n.ct    = w.ct;
    n.sp    = w.sp;
    n.cp    = w.cp;
    n.wx    = w.wx;
    n.wy    = w.wy;
    n.wz    = w.wz;
    n.sing  = w.sing;
    n.ud    = w.ud;
    n.dneg  = w.ct[31];
    n.cp_ct = mul30(w.cp, w.ct);
    n.sp_ct = mul30(w.sp, w.ct);
    n.cp_sf = mul30(w.cp, w.sf);
    n.cf_sp = mul30(w.cf, w.sp);
    n.cf_cp = mul30(w.cf, w.cp);
    n.sf_sp = mul30(w.sf, w.sp);
    n.ct_sf = mul30(w.ct, w.sf);
    n.cf_ct = mul30(w.cf, w.ct);
    return n;
  endfunction

  // second products and the transposed rotation matrix
  function automatic bk_t st2(input bk_t b);
    bk_t                n;
    logic signed [31:0] t1, t2, t3, t4;
    n     = b;
    t1    = mul30(b.cp_sf, b.st);
    t2    = mul30(b.sf_sp, b.st);
    t3    = mul30(b.cf_cp, b.st);
    t4    = mul30(b.cf_sp, b.st);
    n.m00 = 33'(b.cp_ct);
    n.m01 = 33'(b.sp_ct);
    n.m02 = -33'(b.st);
    n.m10 = 33'(t1) - 33'(b.cf_sp);
    n.m11 = 33'(b.cf_cp) + 33'(t2);
    n.m12 = 33'(b.ct_sf);
    n.m20 = 33'(b.sf_sp) + 33'(t3);
    n.m21 = 33'(t4) - 33'(b.cp_sf);
    n.m22 = 33'(b.cf_ct);
    return n;
  endfunction

  // matrix times world rate
  function automatic bk_t st3(input bk_t b);
    bk_t n;
    n     = b;
    n.p00 = b.m00 * b.wx;
    n.p01 = b.m01 * b.wy;
    n.p02 = b.m02 * b.wz;
    n.p10 = b.m10 * b.wx;
    n.p11 = b.m11 * b.wy;
    n.p12 = b.m12 * b.wz;
    n.p20 = b.m20 * b.wx;
    n.p21 = b.m21 * b.wy;
    n.p22 = b.m22 * b.wz;
    return n;
  endfunction

  // body rates in q.20
  function automatic bk_t st4(input bk_t b);
    bk_t                n;
    logic signed [50:0] sx, sy, sz;
    n  = b;
    sx = (51'(b.p00) + 51'(b.p01) + 51'(b.p02) + 51'sd524288) >>> 20;
    sy = (51'(b.p10) + 51'(b.p11) + 51'(b.p12) + 51'sd524288) >>> 20;
    sz = (51'(b.p20) + 51'(b.p21) + 51'(b.p22) + 51'sd524288) >>> 20;
    n.p = sx[31:0];
    n.q = sy[31:0];
    n.r = sz[31:0];
    return n;
  endfunction

  // roll sine and cosine products
  function automatic bk_t st5(input bk_t b);
    bk_t n;
    n    = b;
    n.qs = mul30(b.q, b.sf);
    n.rc = mul30(b.r, b.cf);
    n.qc = mul30(b.q, b.cf);
    n.rs = mul30(b.r, b.sf);
    return n;
  endfunction

  // combined term and pitch rate
  function automatic bk_t st6(input bk_t b);
    bk_t                n;
    logic signed [31:0] us;
    n         = b;
    us        = b.qs + b.rc;
    n.u       = us[30:0];
    n.pitch20 = b.qc - b.rs;
    return n;
  endfunction

  // u times sin pitch
  function automatic bk_t st7(input bk_t b);
    bk_t n;
    n     = b;
    n.ust = b.u * b.st;
    return n;
  endfunction

  // dividend magnitudes with half divisor, signs and overflow
  function automatic bk_t st8(input bk_t b);
    bk_t         n;
    logic [62:0] ma;
    logic [30:0] mu;
    n      = b;
    ma     = b.ust[62] ? 63'(-b.ust) : 63'(b.ust);
    mu     = b.u[30] ? 31'(-b.u) : 31'(b.u);
    n.rr   = ma[59:0] + 60'(b.ud >> 1);
    n.ry   = {mu[29:0], 30'h0} + 60'(b.ud >> 1);
    n.ovr  = {2'b00, n.rr} >= {b.ud, 31'h0};
    n.ovy  = {2'b00, n.ry} >= {b.ud, 31'h0};
    n.negr = b.ust[62] ^ b.dneg;
    n.negy = b.u[30] ^ b.dneg;
    n.qr   = '0;
    n.qy   = '0;
    return n;
  endfunction

  // one restoring division step for both quotients
  function automatic bk_t div_step(input bk_t b, input logic [4:0] k);
    bk_t         n;
    logic [60:0] dv;
    n  = b;
    dv = 61'(b.ud) << k;
    if ({1'b0, b.ry} >= dv) begin
      n.ry    = 60'({1'b0, b.ry} - dv);
      n.qy[k] = 1'b1;
    end
    if ({1'b0, b.rr} >= dv) begin
      n.rr    = 60'({1'b0, b.rr} - dv);
      n.qr[k] = 1'b1;
    end
    return n;
  endfunction

  // signed quotients, final rates
  function automatic eulr_out_t fin(input bk_t b);
    eulr_out_t          o;
    logic [30:0]        qy, qr;
    logic signed [31:0] yv, rv;
    logic signed [32:0] rl;
    qy           = b.ovy ? '1 : b.qy;
    qr           = b.ovr ? '1 : b.qr;
    yv           = b.negy ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
    rv           = b.negr ? -signed'({1'b0, qr}) : signed'({1'b0, qr});
    rl           = 33'(b.p) + 33'(rv);
    o.roll_rate  = to_out(rl);
    o.pitch_rate = to_out(33'(b.pitch20));
    o.yaw_rate   = to_out(33'(yv));
    o.singular   = b.sing;
    return o;
  endfunction

  bk_t            bs [NBV];
  logic [NBV-1:0] bv;
  logic           adv;

  // output register frees the whole back when it drains
  assign adv = !result_valid || result_ready;
  assign pop = adv && q_valid;

  // stage valid bits and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bv           <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      bv           <= {bv[NBV-2:0], q_valid};
      result_valid <= bv[NBV-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      bs[0] <= st1(q_data);
      bs[1] <= st2(bs[0]);
      bs[2] <= st3(bs[1]);
      bs[3] <= st4(bs[2]);
      bs[4] <= st5(bs[3]);
      bs[5] <= st6(bs[4]);
      bs[6] <= st7(bs[5]);
      bs[7] <= st8(bs[6]);
      for (int j = 0; j < NDIV; j++) begin
        bs[NPRE+j] <= div_step(bs[NPRE-1+j], 5'(NDIV - 1 - j));
      end
      result <= fin(bs[NBV-1]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/euler_rates_from_angular_velocity.sv =====
// top level of the zyx euler rate block: config register, front, queue and back
// depends on eulr_pkg, eulr_front, eulr_fifo, eulr_back
//
// usage
//   item channel (item_valid / item_ready / item) takes one word per cycle while ready:
//   roll, pitch, yaw as binary angles and a world-frame angular velocity.
//   result channel (result_valid / result_ready / result) returns one word
//   per input word, in order: roll, pitch and yaw rates in q9.10 and a
//   singular flag set when |cos pitch| is below min_cos_pitch (zero counts as one).
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes min_cos_pitch,
//   always ready; write it only while the block is idle.
//   throughput is one word per cycle while result_ready is high. a word passes
//   CORDIC_STEPS + 1 cordic stages in the front, the queue, eight
//   product stages, 31 division steps and the output register in the back.
//   when the receiver stalls the output register holds, the back freezes,
//   the 4-deep queue fills and then the front stops taking words.
//   reset empties the pipelines and queue and sets min_cos_pitch to 328.
`default_nettype none

module euler_rates_from_angular_velocity import eulr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  eulr_in_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output eulr_out_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic [14:0] min_cos;
  logic        push;
  logic        pop;
  eulr_wd_t    wr_data;
  eulr_wd_t    rd_data;
  eulr_qstat_t qstat;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cos <= MIN_COS_RESET;
    end else if (cfg_valid) begin
      min_cos <= cfg_data;
    end
  end

  eulr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .min_cos    (min_cos),
    .q_full     (qstat.full),
    .push       (push),
    .wd         (wr_data)
  );

  eulr_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .stat    (qstat)
  );

  eulr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!qstat.empty),
    .q_data       (rd_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("word popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && qstat.empty) else $error("reset left words in flight");
`endif

endmodule

`default_nettype wire
